// ----- sv/adts_frame_deframer_defines.svh -----
// Assertion macros used by the checker file of the ADTS deframer.
// No dependencies; include by bare file name.
`ifndef ADTS_FRAME_DEFRAMER_DEFINES_SVH
`define ADTS_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define ADTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ADTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/adts_pkg.sv -----
// Types and constants shared by the ADTS deframer modules.
// No dependencies.
package adts_pkg;

	localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
	localparam logic [3:0]  SYNC_NIBBLE  = 4'hF;
	localparam logic [12:0] HEADER_LEN   = 13'd7;
	localparam logic [2:0]  HDR_LAST_CNT = 3'd6;
	localparam logic [2:0]  SYNC_CNT     = 3'd2;
	localparam int          QUEUE_DEPTH  = 4;
	localparam int          QUEUE_AW     = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        last_of_frame;
		logic [3:0]  rate_index;
		logic [2:0]  channel_config;
		logic [12:0] frame_payload_length;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// ----- sv/adts_if.sv -----
// Valid/ready channel interfaces for the ADTS deframer: byte input, payload output.
// No dependencies.
interface adts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface adts_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic        last_of_frame;
	logic [3:0]  rate_index;
	logic [2:0]  channel_config;
	logic [12:0] frame_payload_length;

	modport source (output valid, output payload_byte, output last_of_frame,
		output rate_index, output channel_config, output frame_payload_length, input ready);
	modport sink (input valid, input payload_byte, input last_of_frame,
		input rate_index, input channel_config, input frame_payload_length, output ready);
endinterface

// ----- sv/adts_parse.sv -----
// Front end: sync hunt, header collection and payload tagging, one byte per cycle while take is high.
// Depends on adts_pkg.
module adts_parse import adts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  data_byte,
	output logic        push,
	output result_t     push_data
);

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_HEAD = 2'd1,
		PH_LOAD = 2'd2
	} phase_t;

	phase_t      phase_q;
	logic [2:0]  cnt_q;
	logic [31:0] hdr_q;
	logic [12:0] rem_q;
	logic [3:0]  rate_q;
	logic [2:0]  chan_q;
	logic [12:0] plen_q;

	logic [12:0] flen;
	logic        last;

	assign flen = hdr_q[17:5];
	assign last = (rem_q <= 13'd1);

	assign push = take && (phase_q == PH_LOAD);
	assign push_data = '{payload_byte: data_byte, last_of_frame: last, rate_index: rate_q,
		channel_config: chan_q, frame_payload_length: plen_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cnt_q   <= '0;
			hdr_q   <= '0;
			rem_q   <= '0;
			rate_q  <= '0;
			chan_q  <= '0;
			plen_q  <= '0;
		end else if (take) begin
			unique case (phase_q)
				PH_HEAD: begin
					if (cnt_q == HDR_LAST_CNT) begin
						cnt_q <= '0;
						if (flen <= HEADER_LEN) begin
							phase_q <= PH_HUNT;
							hdr_q   <= '0;
						end else begin
							hdr_q   <= {hdr_q[23:0], data_byte};
							rate_q  <= hdr_q[29:26];
							chan_q  <= hdr_q[24:22];
							plen_q  <= flen - HEADER_LEN;
							rem_q   <= flen - HEADER_LEN;
							phase_q <= PH_LOAD;
						end
					end else begin
						hdr_q <= {hdr_q[23:0], data_byte};
						cnt_q <= cnt_q + 3'd1;
					end
				end
				PH_LOAD: begin
					if (last) begin
						rem_q   <= '0;
						phase_q <= PH_HUNT;
						cnt_q   <= '0;
						hdr_q   <= '0;
					end else begin
						rem_q <= rem_q - 13'd1;
					end
				end
				default: begin
					hdr_q <= {hdr_q[23:0], data_byte};
					if (hdr_q[7:0] == SYNC_BYTE && data_byte[7:4] == SYNC_NIBBLE) begin
						cnt_q   <= SYNC_CNT;
						phase_q <= PH_HEAD;
					end else begin
						cnt_q   <= '0;
						phase_q <= PH_HUNT;
					end
				end
			endcase
		end
	end

endmodule

// ----- sv/adts_queue.sv -----
// Four-entry result queue between the parser and the output stage.
// Depends on adts_pkg.
module adts_queue import adts_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  result_t       push_data,
	input  logic          pop,
	output result_t       head,
	output queue_status_t status
);

	result_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign status.full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/adts_emit.sv -----
// Back end: output register that drains the result queue onto the output channel.
// Depends on adts_pkg.
module adts_emit import adts_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  result_t       head,
	input  queue_status_t status,
	output logic          pop,
	input  logic          out_ready,
	output logic          out_valid,
	output result_t       out_data
);

	logic    valid_q;
	result_t data_q;

	assign pop       = !status.empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= !status.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= head;
		end
	end

endmodule

// ----- sv/adts_frame_deframer.sv -----
// ADTS deframer: takes one stream byte per cycle and, after a byte-aligned 0xFFF sync and a
// fixed 7-byte header, passes the frame's payload bytes out tagged with the sampling rate
// index, channel configuration and payload length of that frame. Input ready stays high
// except when the four-entry result queue is full, so one byte is accepted every cycle for
// as long as the output side keeps taking results. A payload byte passes through the result
// queue and the output register, and is held there while the output is stalled. Frames
// whose length field is 7 or less are dropped and the sync hunt restarts.
// Depends on adts_pkg and adts_if.
module adts_frame_deframer import adts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	adts_in_if.sink     byte_in,
	adts_out_if.source  pay_out
);

	logic          push;
	result_t       push_data;
	logic          pop;
	result_t       head;
	queue_status_t status;
	logic          take;
	result_t       out_data;

	assign byte_in.ready = !status.full;
	assign take = byte_in.valid && !status.full;

	adts_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (byte_in.data_byte),
		.push      (push),
		.push_data (push_data)
	);

	adts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (status)
	);

	adts_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.status    (status),
		.pop       (pop),
		.out_ready (pay_out.ready),
		.out_valid (pay_out.valid),
		.out_data  (out_data)
	);

	assign pay_out.payload_byte         = out_data.payload_byte;
	assign pay_out.last_of_frame        = out_data.last_of_frame;
	assign pay_out.rate_index           = out_data.rate_index;
	assign pay_out.channel_config       = out_data.channel_config;
	assign pay_out.frame_payload_length = out_data.frame_payload_length;

endmodule

// ----- sv/adts_checker.sv -----
// Port-level checks for the ADTS deframer, bound to the top level.
// Depends on adts_frame_deframer_defines.svh.
`include "adts_frame_deframer_defines.svh"

module adts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  payload_byte,
	input logic        last_of_frame,
	input logic [3:0]  rate_index,
	input logic [2:0]  channel_config,
	input logic [12:0] frame_payload_length
);

	`ADTS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(payload_byte) && $stable(last_of_frame) && $stable(rate_index) && $stable(channel_config) && $stable(frame_payload_length),
		"stalled item changed")

	`ADTS_ASSERT_NOW(a_len_nonzero, clk, arst_n, out_valid, frame_payload_length != 13'd0,
		"zero payload length on output")

	`ADTS_ASSERT_NOW(a_single_last, clk, arst_n, out_valid && frame_payload_length == 13'd1,
		last_of_frame, "one-byte frame not marked last")

endmodule

bind adts_frame_deframer adts_checker u_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.out_valid            (pay_out.valid),
	.out_ready            (pay_out.ready),
	.payload_byte         (pay_out.payload_byte),
	.last_of_frame        (pay_out.last_of_frame),
	.rate_index           (pay_out.rate_index),
	.channel_config       (pay_out.channel_config),
	.frame_payload_length (pay_out.frame_payload_length)
);

// ----- sim/testbench.sv -----
// Testbench for adts_frame_deframer: drives an ADTS byte stream and checks payload items
// against a built-in deframer predictor kept in a small scoreboard class.
// Depends on adts_pkg, adts_if and the adts_frame_deframer RTL.
`timescale 1ns / 1ps

module testbench;
	import adts_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_LIMIT = 50000;

	typedef enum logic [1:0] {PH_HUNT, PH_HEAD, PH_LOAD} parse_phase_t;

	class deframe_scoreboard;
		parse_phase_t phase;
		logic [2:0]   hdr_count;
		logic [55:0]  hdr_shift;
		logic [12:0]  remaining;
		logic [3:0]   rate;
		logic [2:0]   chan;
		logic [12:0]  pay_len;
		result_t      expected_q[$];
		int           errors;

		function new();
			phase = PH_HUNT;
			hdr_count = '0;
			hdr_shift = '0;
			remaining = '0;
			rate = '0;
			chan = '0;
			pay_len = '0;
			errors = 0;
		endfunction

		function void restart_hunt();
			phase = PH_HUNT;
			hdr_count = '0;
			hdr_shift = '0;
		endfunction

		function void note_byte(logic [7:0] b);
			logic [12:0] flen;
			logic        last;
			result_t     r;
			case (phase)
				PH_HEAD: begin
					hdr_shift = {hdr_shift[47:0], b};
					hdr_count = hdr_count + 3'd1;
					if (hdr_count >= HEADER_LEN[2:0]) begin
						flen = hdr_shift[25:13];
						if (flen <= HEADER_LEN) begin
							restart_hunt();
						end else begin
							rate = hdr_shift[37:34];
							chan = hdr_shift[32:30];
							pay_len = flen - HEADER_LEN;
							remaining = pay_len;
							phase = PH_LOAD;
							hdr_count = '0;
						end
					end
				end
				PH_LOAD: begin
					last = (remaining <= 13'd1);
					r.payload_byte = b;
					r.last_of_frame = last;
					r.rate_index = rate;
					r.channel_config = chan;
					r.frame_payload_length = pay_len;
					expected_q.push_back(r);
					if (last) begin
						remaining = '0;
						restart_hunt();
					end else begin
						remaining = remaining - 13'd1;
					end
				end
				default: begin
					if (hdr_shift[7:0] == SYNC_BYTE && b[7:4] == SYNC_NIBBLE) begin
						hdr_shift = {40'd0, hdr_shift[7:0], b};
						hdr_count = 3'd2;
						phase = PH_HEAD;
					end else begin
						hdr_shift = {48'd0, b};
						hdr_count = '0;
						phase = PH_HUNT;
					end
				end
			endcase
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected payload item %h", got.payload_byte));
			end else begin
				want = expected_q.pop_front();
				if (got.payload_byte !== want.payload_byte)
					report($sformatf("payload_byte %h, want %h",
						got.payload_byte, want.payload_byte));
				if (got.last_of_frame !== want.last_of_frame)
					report($sformatf("last_of_frame %b, want %b",
						got.last_of_frame, want.last_of_frame));
				if (got.rate_index !== want.rate_index)
					report($sformatf("rate_index %h, want %h",
						got.rate_index, want.rate_index));
				if (got.channel_config !== want.channel_config)
					report($sformatf("channel_config %h, want %h",
						got.channel_config, want.channel_config));
				if (got.frame_payload_length !== want.frame_payload_length)
					report($sformatf("frame_payload_length %0d, want %0d",
						got.frame_payload_length, want.frame_payload_length));
			end
		endtask

		task check_leftover();
			if (expected_q.size() != 0)
				report($sformatf("%0d payload items never arrived", expected_q.size()));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   cyc_count;
	int   stall_cyc;
	int   burst_left;
	int   frame_bytes;
	deframe_scoreboard sb;

	adts_in_if  byte_in_if();
	adts_out_if pay_out_if();

	adts_frame_deframer u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in_if),
		.pay_out (pay_out_if)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cyc_count++;
		if (cyc_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver stall pattern: always ready, mostly ready, periodic stall, mostly stalled
	always @(negedge clk) begin
		stall_cyc++;
		case ((stall_cyc / 256) % 4)
			0: pay_out_if.ready <= 1'b1;
			1: pay_out_if.ready <= ($urandom_range(0, 3) != 0);
			2: pay_out_if.ready <= ((stall_cyc % 5) != 0);
			default: pay_out_if.ready <= ($urandom_range(0, 9) < 3);
		endcase
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (byte_in_if.valid && byte_in_if.ready)
				sb.note_byte(byte_in_if.data_byte);
			if (pay_out_if.valid && pay_out_if.ready) begin
				got.payload_byte = pay_out_if.payload_byte;
				got.last_of_frame = pay_out_if.last_of_frame;
				got.rate_index = pay_out_if.rate_index;
				got.channel_config = pay_out_if.channel_config;
				got.frame_payload_length = pay_out_if.frame_payload_length;
				sb.check_result(got);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
			burst_left = $urandom_range(1, 30);
			repeat (gap) begin
				@(negedge clk);
				byte_in_if.valid <= 1'b0;
			end
		end
		@(negedge clk);
		byte_in_if.valid <= 1'b1;
		byte_in_if.data_byte <= b;
		do
			@(posedge clk);
		while (!byte_in_if.ready);
		burst_left--;
	endtask

	task automatic send_header(input logic [3:0] rate, input logic [2:0] chan,
		input logic [12:0] flen);
		logic [31:0] r;
		logic [55:0] h;
		r = $urandom;
		h = {SYNC_BYTE, SYNC_NIBBLE, r[3:0], r[5:4], rate, r[6], chan, r[10:7], flen, r[23:11]};
		for (int i = 6; i >= 0; i--)
			send_byte(h[i*8 +: 8]);
		frame_bytes += 7;
	endtask

	task automatic send_payload(input int n);
		for (int i = 0; i < n; i++)
			send_byte(8'($urandom_range(0, 255)));
		frame_bytes += n;
	endtask

	task automatic send_frame(input logic [3:0] rate, input logic [2:0] chan,
		input logic [12:0] flen);
		send_header(rate, chan, flen);
		if (flen > HEADER_LEN)
			send_payload(int'(flen - HEADER_LEN));
	endtask

	task automatic wait_drained();
		int w;
		w = 0;
		@(negedge clk);
		byte_in_if.valid <= 1'b0;
		burst_left = 0;
		while (sb.expected_q.size() != 0 && w < DRAIN_LIMIT) begin
			@(posedge clk);
			w++;
		end
	endtask

	task automatic random_traffic(input int target);
		int kind;
		int n;
		logic [12:0] flen;
		while (frame_bytes < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				repeat ($urandom_range(0, 2))
					send_byte(8'($urandom_range(0, 255)));
				flen = ($urandom_range(0, 9) != 0) ? 13'(8 + $urandom_range(0, 30))
					: 13'(8 + $urandom_range(0, 300));
				send_frame(4'($urandom), 3'($urandom), flen);
			end else if (kind < 80) begin
				repeat ($urandom_range(1, 6))
					send_byte($urandom_range(0, 1) ? SYNC_BYTE : 8'($urandom_range(0, 255)));
			end else if (kind < 87) begin
				// extra sync byte ahead of a header: the earlier match wins
				send_byte(SYNC_BYTE);
				send_frame(4'($urandom), 3'($urandom), 13'(8 + $urandom_range(0, 20)));
			end else if (kind < 93) begin
				send_header(4'($urandom), 3'($urandom), 13'($urandom_range(0, 7)));
			end else begin
				flen = 13'(8 + $urandom_range(0, 30));
				n = $urandom_range(0, int'(flen - HEADER_LEN));
				send_header(4'($urandom), 3'($urandom), flen);
				send_payload(n);
			end
		end
	endtask

	initial begin
		sb = new();
		cyc_count = 0;
		stall_cyc = 0;
		burst_left = 0;
		frame_bytes = 0;
		arst_n = 1'b0;
		byte_in_if.valid = 1'b0;
		byte_in_if.data_byte = 8'h00;
		pay_out_if.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sync cannot complete on the first byte of a hunt; broken sync
		send_byte(8'hF1);
		send_byte(SYNC_BYTE);
		send_byte(8'h0F);
		// short frame, then a one-byte payload at the field extremes
		send_header(4'hF, 3'h7, 13'd0);
		send_header(4'hF, 3'h7, 13'd8);
		send_byte(SYNC_BYTE);
		// hunt restarts after a frame: a trailing 0xFF payload does not count
		send_byte(8'hF5);
		send_header(4'h0, 3'h0, 13'd7);
		send_byte(SYNC_BYTE);
		send_frame(4'h0, 3'h0, 13'd9);
		wait_drained();

		random_traffic(550);
		wait_drained();
		random_traffic(1000);
		// largest length field; the run ends inside this frame
		send_header(4'($urandom), 3'($urandom), 13'h1FFF);
		send_payload(60);

		wait_drained();
		repeat (20) @(posedge clk);
		sb.check_leftover();
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
